// ----- hw/rtl/pop3_message_dot_stuffer_top_macros.svh -----
// Assertion macros for the POP3 message dot stuffer.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef POP3_MESSAGE_DOT_STUFFER_TOP_MACROS_SVH
`define POP3_MESSAGE_DOT_STUFFER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define P3DS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define P3DS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define P3DS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define P3DS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/p3ds_pkg.sv -----
// Package for the POP3 message dot stuffer: character codes, register indexes,
// widths and the line limit saturation function. No dependencies.
package p3ds_pkg;

   localparam int LINE_COUNT_BITS = 16;
   localparam int MAX_RESULTS = 9;
   localparam int RESULT_COUNT_BITS = $clog2(MAX_RESULTS + 1);
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEND_WHOLE_BODY = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BODY_LINE_LIMIT = 1'd1;

   localparam logic [32:0] LINE_COUNT_MAX_WIDE = (33'd1 << LINE_COUNT_BITS) - 33'd1;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } entry_type;

   function automatic logic [LINE_COUNT_BITS-1:0] sat_limit(input logic [15:0] limit);
      logic [32:0] wide;
      wide = 33'(limit);
      if (wide > LINE_COUNT_MAX_WIDE) begin
         return '1;
      end
      return wide[LINE_COUNT_BITS-1:0];
   endfunction

endpackage

// ----- hw/rtl/pop3_message_dot_stuffer_top.sv -----
// Top level of the POP3 message dot stuffer: input register, expansion logic
// and a shifting result buffer. Depends on p3ds_pkg and the assertion macro header.
//
// One message byte that yields at most one output byte is taken per cycle while
// the output does not stall; one that expands holds the input until the result
// buffer, which drains one byte per cycle unless stalled, is reloaded as its last
// byte leaves. Bytes of the From line and of a body past its limit produce nothing
// and pass at one per cycle. The final byte of a message adds the terminator.
`include "pop3_message_dot_stuffer_top_macros.svh"

module pop3_message_dot_stuffer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_in_byte,
   input  logic                                 req_end_of_message,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_last_out,
   input  logic                                 csr_write_en,
   input  logic [p3ds_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [p3ds_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import p3ds_pkg::*;

   typedef enum logic [1:0] {
      PH_FROM = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2,
      PH_SKIP = 2'd3
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic                       line_start_ff, line_start_in;
   logic [LINE_COUNT_BITS-1:0] lines_left_ff, lines_left_in;
   logic                       send_whole_ff;
   logic [15:0]                limit_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eom_ff;

   entry_type                    buf_ff [MAX_RESULTS];
   logic [RESULT_COUNT_BITS-1:0] count_ff;

   entry_type                    list [MAX_RESULTS];
   logic [RESULT_COUNT_BITS-1:0] n;
   logic                         send_line;
   logic                         skip;
   logic                         pop;
   logic                         load;

   assign rsp_valid    = (count_ff != '0);
   assign rsp_out_byte = buf_ff[0].data;
   assign rsp_last_out = buf_ff[0].last;
   assign pop          = rsp_valid && !rsp_stall;
   assign load         = in_valid_ff &&
                         ((count_ff == '0) || ((count_ff == RESULT_COUNT_BITS'(1)) && pop));
   assign req_stall    = in_valid_ff && !load;

   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         list[i] = '{data: 8'h00, last: 1'b0};
      end
      n             = '0;
      phase_in      = phase_ff;
      line_start_in = line_start_ff;
      lines_left_in = lines_left_ff;
      send_line     = 1'b0;
      skip          = 1'b0;

      case (phase_ff)
         PH_FROM: begin
            if (in_byte_ff == CH_LF) begin
               phase_in      = PH_HEAD;
               line_start_in = 1'b1;
            end
         end
         PH_HEAD: begin
            if (line_start_ff && in_byte_ff == CH_LF) begin
               list[n] = '{data: CH_CR, last: 1'b0};
               n = n + 1'b1;
               list[n] = '{data: CH_LF, last: 1'b0};
               n = n + 1'b1;
               phase_in      = PH_BODY;
               line_start_in = 1'b1;
               lines_left_in = sat_limit(limit_ff);
            end else begin
               send_line = 1'b1;
            end
         end
         PH_BODY: begin
            if (line_start_ff && !send_whole_ff) begin
               if (lines_left_ff == '0) begin
                  phase_in = PH_SKIP;
                  skip     = 1'b1;
               end else begin
                  lines_left_in = lines_left_ff - LINE_COUNT_BITS'(1);
               end
            end
            send_line = !skip;
         end
         default: begin
         end
      endcase

      if (send_line) begin
         if (in_byte_ff == CH_LF) begin
            list[n] = '{data: CH_CR, last: 1'b0};
            n = n + 1'b1;
            list[n] = '{data: CH_LF, last: 1'b0};
            n = n + 1'b1;
            line_start_in = 1'b1;
         end else begin
            if (line_start_ff && in_byte_ff == CH_DOT) begin
               list[n] = '{data: CH_DOT, last: 1'b0};
               n = n + 1'b1;
            end
            list[n] = '{data: in_byte_ff, last: 1'b0};
            n = n + 1'b1;
            line_start_in = 1'b0;
         end
      end

      if (in_eom_ff) begin
         if (!line_start_in && phase_in != PH_FROM) begin
            list[n] = '{data: CH_CR, last: 1'b0};
            n = n + 1'b1;
            list[n] = '{data: CH_LF, last: 1'b0};
            n = n + 1'b1;
         end
         list[n] = '{data: CH_DOT, last: 1'b0};
         n = n + 1'b1;
         list[n] = '{data: CH_CR, last: 1'b0};
         n = n + 1'b1;
         list[n] = '{data: CH_LF, last: 1'b1};
         n = n + 1'b1;
         phase_in      = PH_FROM;
         line_start_in = 1'b1;
         lines_left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FROM;
         line_start_ff <= 1'b1;
         lines_left_ff <= '0;
         send_whole_ff <= 1'b1;
         limit_ff      <= '0;
         in_valid_ff   <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SEND_WHOLE_BODY: send_whole_ff <= csr_wdata[0];
               CSR_BODY_LINE_LIMIT: limit_ff <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (load) begin
            in_valid_ff <= 1'b0;
         end
         if (load) begin
            phase_ff      <= phase_in;
            line_start_ff <= line_start_in;
            lines_left_ff <= lines_left_in;
            count_ff      <= n;
         end else if (pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_eom_ff  <= req_end_of_message;
      end
      if (load) begin
         buf_ff <= list;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            buf_ff[i] <= buf_ff[i + 1];
         end
         buf_ff[MAX_RESULTS - 1] <= '{data: 8'h00, last: 1'b0};
      end
   end

   `P3DS_ASSERT_IMPLIES(a_last_is_lf, clock, reset, rsp_valid && rsp_last_out, rsp_out_byte == CH_LF)
   `P3DS_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= RESULT_COUNT_BITS'(MAX_RESULTS))
   `P3DS_ASSERT_IMPLIES(a_stall_holds_item, clock, reset, req_stall, in_valid_ff && rsp_valid)
   `P3DS_ASSERT_IMPLIES(a_from_line_silent, clock, reset, load && phase_ff == PH_FROM && !in_eom_ff, n == '0)
   `P3DS_ASSERT_NEXT(a_load_sets_count, clock, reset, load && n != '0, rsp_valid)

endmodule
